@@ rtl/core/cbfs_pkg.sv @@
`default_nettype none

package cbfs_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 29;
  localparam int ACTION_W   = 3;
  localparam int DEST_W     = 2;
  localparam int ID_W       = 29;
  localparam int RES_MAX    = 3;
  localparam int QDEPTH     = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_BUS_READY    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINK_TIMEOUT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PREP_TIMEOUT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEEPALIVE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCKED_A    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCKED_B    = 3'd5;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_PEER_PKT  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CAR_FRAME = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LINK_ERR  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CAN_ALERT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd4;

  // Peer packet types
  localparam logic [3:0] PKT_HELLO     = 4'd0;
  localparam logic [3:0] PKT_KEEPALIVE = 4'd1;
  localparam logic [3:0] PKT_PREPARE   = 4'd2;
  localparam logic [3:0] PKT_ACTIVE    = 4'd3;
  localparam logic [3:0] PKT_BYPASS    = 4'd4;
  localparam logic [3:0] PKT_FRAME     = 4'd5;
  localparam logic [3:0] PKT_FAULT     = 4'd6;
  localparam logic [3:0] PKT_READY     = 4'd7;
  localparam logic [3:0] PKT_STOPPED   = 4'd8;
  localparam logic [3:0] PKT_NONE      = 4'd0;

  localparam logic [3:0] MAX_DLC = 4'd8;

  // Result destinations
  localparam logic [DEST_W-1:0] DST_PEER_CTRL  = 2'd0;
  localparam logic [DEST_W-1:0] DST_PEER_FRAME = 2'd1;
  localparam logic [DEST_W-1:0] DST_CAR_TX     = 2'd2;
  localparam logic [DEST_W-1:0] DST_RECOVERY   = 2'd3;

  typedef enum logic [1:0] {
    M_BYPASS   = 2'd0,
    M_PREPARED = 2'd1,
    M_ACTIVE   = 2'd2,
    M_FAULT    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        rx_overrun;
    logic        bus_off;
    logic        downstream_ok;
    logic [63:0] payload;
    logic [3:0]  length;
    logic        remote;
    logic        extended;
    logic [ID_W-1:0] identifier;
    logic [15:0] sequence_req;
    logic [3:0]  pkt_type;
  } in_data_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [1:0]  mode_now;
    logic        flag_active;
    logic        flag_ready;
    logic [63:0] out_payload;
    logic [3:0]  out_length;
    logic        out_remote;
    logic        out_extended;
    logic [ID_W-1:0] out_identifier;
    logic [3:0]  msg_type;
  } out_data_t;

  typedef struct packed {
    logic [ID_W-1:0] identifier;
    logic            extended;
    logic            remote;
    logic [3:0]      length;
    logic [63:0]     payload;
  } frame_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [3:0]        msg_type;
    logic              flag_ready;
    logic              flag_active;
    mode_t             mode_now;
  } desc_t;

  // One accepted item: up to three results; frame fields serve a lone frame result
  typedef struct packed {
    logic [1:0]                cnt;
    desc_t [RES_MAX-1:0]       desc;
    frame_t                    frame;
  } job_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (len > 4'(i)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic desc_t ctl_desc(input logic [3:0] kind, input logic br,
                                     input mode_t m);
    desc_t d;
    d.dest        = DST_PEER_CTRL;
    d.msg_type    = kind;
    d.flag_ready  = br;
    d.flag_active = (m == M_ACTIVE);
    d.mode_now    = m;
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cbfs_front.sv @@
`default_nettype none

module cbfs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cbfs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cbfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cbfs_pkg::ACTION_W-1:0]     in_action,
  input  cbfs_pkg::in_data_t                in_data,
  input  logic                              q_full,
  output logic                              q_push,
  output cbfs_pkg::job_t                    q_job
);
  import cbfs_pkg::*;

  logic            bus_ready_r;
  logic [15:0]     link_to_r;
  logic [15:0]     prep_to_r;
  logic [15:0]     keep_period_r;
  logic [ID_W-1:0] blocked_a_r;
  logic [ID_W-1:0] blocked_b_r;

  mode_t       mode_r, mode_nxt;
  logic        peer_heard_r, peer_heard_nxt;
  logic        seq_seen_r, seq_seen_nxt;
  logic [15:0] seq_last_r, seq_last_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] peer_last_r, peer_last_nxt;
  logic [31:0] prep_at_r, prep_at_nxt;
  logic [31:0] keep_at_r, keep_at_nxt;

  logic        accept;
  logic        fwd;
  logic        seq_ok;
  logic        blocked;
  logic        tx_refused;
  logic [31:0] time_inc;
  logic [31:0] link_gap;
  logic [31:0] prep_gap_tick;
  logic [31:0] keep_gap;
  logic [31:0] prep_gap_now;

  logic [1:0]               n_v;
  desc_t [RES_MAX-1:0]      desc_v;
  frame_t                   frame_v;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign fwd      = (mode_r == M_PREPARED) || (mode_r == M_ACTIVE);

  assign seq_ok = !seq_seen_r || (in_data.sequence_req == seq_last_r + 16'd1);
  assign blocked = (in_data.identifier == blocked_a_r) ||
                   (in_data.identifier == blocked_b_r);
  assign tx_refused = !bus_ready_r || (in_data.length > MAX_DLC) || !in_data.downstream_ok;

  assign time_inc      = time_r + 32'd1;
  assign link_gap      = time_inc - peer_last_r;
  assign prep_gap_tick = time_inc - prep_at_r;
  assign keep_gap      = time_inc - keep_at_r;
  assign prep_gap_now  = time_r - prep_at_r;

  always_comb begin
    mode_nxt       = mode_r;
    peer_heard_nxt = peer_heard_r;
    seq_seen_nxt   = seq_seen_r;
    seq_last_nxt   = seq_last_r;
    time_nxt       = time_r;
    peer_last_nxt  = peer_last_r;
    prep_at_nxt    = prep_at_r;
    keep_at_nxt    = keep_at_r;
    n_v            = '0;
    desc_v         = '0;
    frame_v        = '0;
    if (accept) begin
      unique case (in_action)
        ACT_PEER_PKT: begin
          seq_seen_nxt   = 1'b1;
          seq_last_nxt   = in_data.sequence_req;
          peer_heard_nxt = 1'b1;
          peer_last_nxt  = time_r;
          if (!seq_ok && fwd) begin
            mode_nxt  = M_FAULT;
            desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
            n_v       = 2'd1;
          end else begin
            unique case (in_data.pkt_type)
              PKT_PREPARE: begin
                if (mode_r != M_BYPASS || !bus_ready_r) begin
                  mode_nxt  = M_FAULT;
                  desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
                end else begin
                  mode_nxt    = M_PREPARED;
                  prep_at_nxt = time_r;
                  desc_v[0]   = ctl_desc(PKT_READY, bus_ready_r, M_PREPARED);
                end
                n_v = 2'd1;
              end
              PKT_ACTIVE: begin
                if (mode_r != M_PREPARED || prep_gap_now > {16'd0, prep_to_r}) begin
                  mode_nxt  = M_FAULT;
                  desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
                  n_v       = 2'd1;
                end else begin
                  mode_nxt = M_ACTIVE;
                end
              end
              PKT_BYPASS: begin
                mode_nxt  = (mode_r == M_FAULT) ? M_FAULT : M_BYPASS;
                desc_v[0] = ctl_desc(PKT_STOPPED, bus_ready_r, mode_nxt);
                n_v       = 2'd1;
              end
              PKT_FRAME: begin
                if (mode_r == M_ACTIVE) begin
                  if (blocked || tx_refused) begin
                    mode_nxt  = M_FAULT;
                    desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
                  end else begin
                    desc_v[0].dest     = DST_CAR_TX;
                    desc_v[0].msg_type = PKT_NONE;
                    desc_v[0].mode_now = mode_r;
                    frame_v.identifier = in_data.identifier;
                    frame_v.extended   = in_data.extended;
                    frame_v.remote     = in_data.remote;
                    frame_v.length     = in_data.length;
                    frame_v.payload    = in_data.remote ? 64'd0 :
                                         (in_data.payload & byte_mask(in_data.length));
                  end
                  n_v = 2'd1;
                end
              end
              PKT_FAULT, PKT_READY, PKT_STOPPED: begin
                mode_nxt  = M_FAULT;
                desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
                n_v       = 2'd1;
              end
              default: begin
                // hello, keepalive and unknown types only refresh link timing and sequence tracking
              end
            endcase
          end
        end
        ACT_CAR_FRAME: begin
          if (in_data.downstream_ok) begin
            desc_v[0].dest        = DST_PEER_FRAME;
            desc_v[0].msg_type    = PKT_FRAME;
            desc_v[0].flag_ready  = bus_ready_r;
            desc_v[0].flag_active = (mode_r == M_ACTIVE);
            desc_v[0].mode_now    = mode_r;
            frame_v.identifier    = in_data.identifier;
            frame_v.extended      = in_data.extended;
            frame_v.remote        = in_data.remote;
            frame_v.length        = in_data.length;
            frame_v.payload       = in_data.payload & byte_mask(in_data.length);
            n_v                   = 2'd1;
          end else if (mode_r == M_ACTIVE) begin
            mode_nxt  = M_FAULT;
            desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
            n_v       = 2'd1;
          end
        end
        ACT_LINK_ERR: begin
          if (fwd) begin
            mode_nxt  = M_FAULT;
            desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
            n_v       = 2'd1;
          end
        end
        ACT_CAN_ALERT: begin
          if (in_data.bus_off) begin
            mode_nxt           = M_FAULT;
            desc_v[0]          = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
            desc_v[1].dest     = DST_RECOVERY;
            desc_v[1].mode_now = M_FAULT;
            n_v                = 2'd2;
          end
          if (in_data.rx_overrun) begin
            mode_nxt      = M_FAULT;
            desc_v[n_v]   = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
            n_v           = n_v + 2'd1;
          end
        end
        ACT_TICK: begin
          time_nxt = time_inc;
          // link loss first; once in fault the prepare timeout cannot fire
          if (fwd && (!peer_heard_r || link_gap > {16'd0, link_to_r})) begin
            mode_nxt  = M_FAULT;
            desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
            n_v       = 2'd1;
          end else if (mode_r == M_PREPARED && prep_gap_tick > {16'd0, prep_to_r}) begin
            mode_nxt  = M_FAULT;
            desc_v[0] = ctl_desc(PKT_FAULT, bus_ready_r, M_FAULT);
            n_v       = 2'd1;
          end
          if (keep_gap >= {16'd0, keep_period_r}) begin
            desc_v[n_v] = ctl_desc(PKT_KEEPALIVE, bus_ready_r, mode_nxt);
            n_v         = n_v + 2'd1;
            keep_at_nxt = time_inc;
          end
        end
        default: begin
          // unused actions: drop
        end
      endcase
    end
  end

  assign q_push      = accept && (n_v != 2'd0);
  assign q_job.cnt   = n_v;
  assign q_job.desc  = desc_v;
  assign q_job.frame = frame_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_ready_r   <= 1'b0;
      link_to_r     <= 16'd100;
      prep_to_r     <= 16'd1000;
      keep_period_r <= 16'd50;
      blocked_a_r   <= ID_W'(1010);
      blocked_b_r   <= ID_W'(1294);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BUS_READY:    bus_ready_r   <= cfg_wdata[0];
        CFG_LINK_TIMEOUT: link_to_r     <= cfg_wdata[15:0];
        CFG_PREP_TIMEOUT: prep_to_r     <= cfg_wdata[15:0];
        CFG_KEEPALIVE:    keep_period_r <= cfg_wdata[15:0];
        CFG_BLOCKED_A:    blocked_a_r   <= cfg_wdata[ID_W-1:0];
        CFG_BLOCKED_B:    blocked_b_r   <= cfg_wdata[ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_BYPASS;
      peer_heard_r <= 1'b0;
      seq_seen_r   <= 1'b0;
      seq_last_r   <= 16'd0;
      time_r       <= 32'd0;
      peer_last_r  <= 32'd0;
      prep_at_r    <= 32'd0;
      keep_at_r    <= 32'd0;
    end else begin
      mode_r       <= mode_nxt;
      peer_heard_r <= peer_heard_nxt;
      seq_seen_r   <= seq_seen_nxt;
      seq_last_r   <= seq_last_nxt;
      time_r       <= time_nxt;
      peer_last_r  <= peer_last_nxt;
      prep_at_r    <= prep_at_nxt;
      keep_at_r    <= keep_at_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_FAULT) |=> (mode_r == M_FAULT))
    else $error("fault mode left without reset");

  a_active_needs_peer: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_ACTIVE) |-> (peer_heard_r && seq_seen_r))
    else $error("active mode without any peer packet seen");
`endif

endmodule

`default_nettype wire

@@ rtl/core/cbfs_queue.sv @@
`default_nettype none

module cbfs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cbfs_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cbfs_pkg::job_t  head_job
);
  import cbfs_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("item pushed into full queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/cbfs_back.sv @@
`default_nettype none

module cbfs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  cbfs_pkg::job_t                 q_job,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [$bits(cbfs_pkg::out_data_t)-1:0] out_tdata,
  output logic [cbfs_pkg::DEST_W-1:0]    out_tuser,
  output logic                           out_tlast
);
  import cbfs_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        idx_r, idx_nxt;
  out_data_t         out_data_r;
  logic [DEST_W-1:0] out_dest_r;
  logic              out_last_r;
  logic              load;
  logic              last_v;
  desc_t             cur;

  assign cur    = q_job.desc[idx_r];
  assign load   = q_valid && (!out_valid_r || out_tready);
  assign last_v = (idx_r == q_job.cnt - 2'd1);
  assign q_pop  = load && last_v;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_v ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Frame fields are zero in every job that carries more than one result
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.pad            <= '0;
      out_data_r.mode_now       <= cur.mode_now;
      out_data_r.flag_active    <= cur.flag_active;
      out_data_r.flag_ready     <= cur.flag_ready;
      out_data_r.out_payload    <= q_job.frame.payload;
      out_data_r.out_length     <= q_job.frame.length;
      out_data_r.out_remote     <= q_job.frame.remote;
      out_data_r.out_extended   <= q_job.frame.extended;
      out_data_r.out_identifier <= q_job.frame.identifier;
      out_data_r.msg_type       <= cur.msg_type;
      out_dest_r                <= cur.dest;
      out_last_r                <= last_v;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dest_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_last_r))
    else $error("job retired without a final result");
`endif

endmodule

`default_nettype wire

@@ rtl/core/can_bridge_forwarding_supervisor_core.sv @@
`default_nettype none

// CAN forwarding supervisor between a peer link and a car bus.
// Input channel in_*: one event per item; in_tuser holds the action (peer
// packet, car frame, link decode error, CAN alert, millisecond tick) and
// in_tdata the packet and frame fields. Result channel out_*: control
// packets, forwarded frames, car transmits and bus-recovery requests;
// out_tuser holds the destination and out_tlast marks the final result of
// an input item. Items that cause no result give nothing on out_*.
// Configuration: cfg_we writes register cfg_addr from cfg_wdata; the user
// must write only while the block is idle, which the block does not enforce.
// The first result of an item passes the job queue and then the output
// register. Throughput: an item is accepted every cycle while the
// two-entry job queue has room; the output register hands out one result
// a cycle while out_tready is high, and an item carries one to three
// results.
// Reset (rst_n low, synchronous) returns to bypass mode with default
// registers, clears time and sequence tracking and empties the queue.
// A stalled receiver holds the current result; the queue then fills and
// in_tready drops until results are taken.
module can_bridge_forwarding_supervisor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [cbfs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cbfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pkt_type, sequence_req, identifier, extended, remote, length, payload,
  // downstream_ok, bus_off, rx_overrun, zero fill
  input  logic [$bits(cbfs_pkg::in_data_t)-1:0] in_tdata,
  // action
  input  logic [cbfs_pkg::ACTION_W-1:0] in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // msg_type, out_identifier, out_extended, out_remote, out_length,
  // out_payload, flag_ready, flag_active, mode_now, zero fill
  output logic [$bits(cbfs_pkg::out_data_t)-1:0] out_tdata,
  // dest
  output logic [cbfs_pkg::DEST_W-1:0] out_tuser,
  output logic        out_tlast
);
  import cbfs_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t head_job;

  cbfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_data   (in_data_t'(in_tdata)),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  cbfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  cbfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
